// ===== sv/sjfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sjfs_pkg: shared types and constants of the job scheduler
// Field widths, item and status codes, the table entry layout and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sjfs_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 16;

    // Fixed field widths of the item and result beats.
    localparam int KIND_W   = 2;
    localparam int ID_W     = 8;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;

    // Configuration port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // Item kinds; the two spare codes are handled as a clear.
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_LOADED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RAN      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_IDLE     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

    // One job table entry as held in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] remaining;
        logic [FIELD_W-1:0] burst;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic cnt_clear;
        logic cnt_inc;
        logic scan_start;
        logic scan_read;
        logic sel_lock;
        logic sel_best;
        logic read_sel;
        logic load;
        logic reject;
        logic clear;
        logic idle_tick;
        logic exec;
        logic publish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind_load;
        logic kind_tick;
        logic burst_zero;
        logic lock_use;
        logic slot_free;
        logic cnt_last;
        logic best_none;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/shortest_job_first_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_top: job table scheduler, shortest job first
// Top level with the configuration register, the controller and the
// datapath.
// ----------------------------------------------------------------------------
// The block takes one item at a time and gives one result beat per item.
// A tick that has to choose a job scans the slot memory one slot per cycle
// through its single registered read port; a tick that keeps a held job in
// non-preemptive mode skips the scan. A load searches the valid bits from
// the lowest slot, one per cycle; a clear or a zero-burst load skips the
// search. Each result waits while the previous result still blocks the
// output register. A new item is taken while the previous result still
// waits in the output register.
// Register 0 at byte address 0, bit 0, selects preemptive mode (reset 1);
// write it only while the block is idle.
module shortest_job_first_scheduler_top #(
    parameter int TABLE_DEPTH = sjfs_pkg::DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = sjfs_pkg::DEF_TIME_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Item channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sjfs_pkg::KIND_W-1:0]    s_kind,
    input  logic [sjfs_pkg::ID_W-1:0]      s_job_id,
    input  logic [sjfs_pkg::FIELD_W-1:0]   s_arrival_time,
    input  logic [sjfs_pkg::FIELD_W-1:0]   s_burst_length,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sjfs_pkg::STATUS_W-1:0]  m_status,
    output logic [sjfs_pkg::ID_W-1:0]      m_running_id,
    output logic                           m_job_done,
    output logic [sjfs_pkg::FIELD_W-1:0]   m_finish_time,
    output logic [sjfs_pkg::FIELD_W-1:0]   m_turnaround,
    output logic [sjfs_pkg::FIELD_W-1:0]   m_waiting,
    output logic [sjfs_pkg::FIELD_W-1:0]   m_now_time,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sjfs_pkg::PADDR_W-1:0]   paddr,
    input  logic [sjfs_pkg::PDATA_W-1:0]   pwdata,
    output logic [sjfs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    sjfs_pkg::ctrl_cmd_t cmd;
    sjfs_pkg::dp_stat_t  stat;
    logic                preempt_reg, preempt_next;
    logic                cfg_write;

    // Configuration register; the port holds a single word.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        preempt_next = preempt_reg;
        if (cfg_write) begin
            preempt_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preempt_reg <= 1'b1;
        end else begin
            preempt_reg <= preempt_next;
        end
    end

    // Read-back of the register; every byte offset lands on the same word.
    assign prdata = {{(sjfs_pkg::PDATA_W-1){1'b0}}, preempt_reg} |
                    {sjfs_pkg::PDATA_W{1'b0 & paddr[0]}};

    // Sequencer.
    sjfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Job table, selection and result path.
    sjfs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .preempt        (preempt_reg),
        .s_kind         (s_kind),
        .s_job_id       (s_job_id),
        .s_arrival_time (s_arrival_time),
        .s_burst_length (s_burst_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_running_id   (m_running_id),
        .m_job_done     (m_job_done),
        .m_finish_time  (m_finish_time),
        .m_turnaround   (m_turnaround),
        .m_waiting      (m_waiting),
        .m_now_time     (m_now_time),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

// ===== sv/sjfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sjfs_ctrl: sequencing state machine of the job scheduler
// Accepts one item at a time and steps the datapath through the free-slot
// search, the selection scan, the update and the hand-off of the result.
// ----------------------------------------------------------------------------
module sjfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sjfs_pkg::dp_stat_t  stat,
    output sjfs_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DISPATCH  = 9'b000000010,
        ST_FREE_SCAN = 9'b000000100,
        ST_TICK_SCAN = 9'b000001000,
        ST_TICK_LAST = 9'b000010000,
        ST_SELECT    = 9'b000100000,
        ST_READ      = 9'b001000000,
        ST_EXEC      = 9'b010000000,
        ST_RESULT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.kind_load) begin
                    if (stat.burst_zero) begin
                        cmd.reject = 1'b1;
                        state_next = ST_RESULT;
                    end else begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_FREE_SCAN;
                    end
                end else if (stat.kind_tick) begin
                    if (stat.lock_use) begin
                        cmd.sel_lock = 1'b1;
                        state_next   = ST_READ;
                    end else begin
                        cmd.cnt_clear  = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_TICK_SCAN;
                    end
                end else begin
                    cmd.clear  = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_FREE_SCAN: begin
                if (stat.slot_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RESULT;
                end else if (stat.cnt_last) begin
                    cmd.reject = 1'b1;
                    state_next = ST_RESULT;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_TICK_SCAN: begin
                cmd.scan_read = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_TICK_LAST;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_TICK_LAST: begin
                // The last slot read is compared in this cycle.
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                if (stat.best_none) begin
                    cmd.idle_tick = 1'b1;
                    state_next    = ST_RESULT;
                end else begin
                    cmd.sel_best = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_sel = 1'b1;
                state_next   = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/sjfs_dp.sv =====
// ----------------------------------------------------------------------------
// sjfs_dp: datapath of the job scheduler
// Holds the slot memory, the valid bits, time and lock state, the scan
// comparator, the result staging registers and the output register.
// ----------------------------------------------------------------------------
module sjfs_dp #(
    parameter int TABLE_DEPTH = sjfs_pkg::DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = sjfs_pkg::DEF_TIME_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                preempt,
    input  logic [sjfs_pkg::KIND_W-1:0]         s_kind,
    input  logic [sjfs_pkg::ID_W-1:0]           s_job_id,
    input  logic [sjfs_pkg::FIELD_W-1:0]        s_arrival_time,
    input  logic [sjfs_pkg::FIELD_W-1:0]        s_burst_length,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sjfs_pkg::STATUS_W-1:0]       m_status,
    output logic [sjfs_pkg::ID_W-1:0]           m_running_id,
    output logic                                m_job_done,
    output logic [sjfs_pkg::FIELD_W-1:0]        m_finish_time,
    output logic [sjfs_pkg::FIELD_W-1:0]        m_turnaround,
    output logic [sjfs_pkg::FIELD_W-1:0]        m_waiting,
    output logic [sjfs_pkg::FIELD_W-1:0]        m_now_time,
    input  sjfs_pkg::ctrl_cmd_t                 cmd,
    output sjfs_pkg::dp_stat_t                  stat
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int FW    = sjfs_pkg::FIELD_W;
    localparam int CMP_W = (TIME_BITS > FW) ? TIME_BITS : FW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Slot memory and its registered read port.
    sjfs_pkg::entry_t slot_mem_reg [TABLE_DEPTH];
    sjfs_pkg::entry_t rd_data_reg;
    sjfs_pkg::entry_t wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // Table control state.
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic                   lock_held_reg, lock_held_next;
    logic [IDX_W-1:0]       locked_reg, locked_next;

    // Captured item.
    logic [sjfs_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [sjfs_pkg::ID_W-1:0]   id_reg, id_next;
    logic [FW-1:0]               arr_reg, arr_next;
    logic [FW-1:0]               burst_reg, burst_next;

    // Scan counter, read pipeline and best candidate.
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0] pipe_slot_reg, pipe_slot_next;
    logic             pipe_ok_reg, pipe_ok_next;
    logic             best_none_reg, best_none_next;
    logic [IDX_W-1:0] best_slot_reg, best_slot_next;
    logic [FW-1:0]    best_rem_reg, best_rem_next;
    logic [FW-1:0]    best_arr_reg, best_arr_next;
    logic [IDX_W-1:0] k_reg, k_next;

    // Staged result.
    logic [sjfs_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [sjfs_pkg::ID_W-1:0]     res_id_reg, res_id_next;
    logic                          res_done_reg, res_done_next;
    logic [FW-1:0]                 res_fin_reg, res_fin_next;
    logic [FW-1:0]                 res_tat_reg, res_tat_next;
    logic [FW-1:0]                 res_wait_reg, res_wait_next;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic [sjfs_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [sjfs_pkg::ID_W-1:0]     m_id_reg, m_id_next;
    logic                          m_done_reg, m_done_next;
    logic [FW-1:0]                 m_fin_reg, m_fin_next;
    logic [FW-1:0]                 m_tat_reg, m_tat_next;
    logic [FW-1:0]                 m_wait_reg, m_wait_next;
    logic [FW-1:0]                 m_now_reg, m_now_next;

    // Shared arithmetic.
    logic [TIME_BITS-1:0] time_inc;
    logic [CMP_W-1:0]     time_ext;
    logic                 eligible;
    logic                 better;
    logic [FW-1:0]        rem_new;
    logic                 finished;
    logic [CMP_W-1:0]     fin_w;
    logic [CMP_W-1:0]     tat_w;
    logic [CMP_W-1:0]     wait_w;
    logic [CMP_W-1:0]     burst_ext;

    // Time advances by one unit and holds at its largest value.
    assign time_inc = (time_reg == {TIME_BITS{1'b1}}) ? time_reg : time_reg + 1'b1;
    assign time_ext = CMP_W'(time_reg);

    // A scanned slot competes when valid and already arrived; ties on the
    // remaining burst go to the earlier arrival, then to the lower slot.
    assign eligible = pipe_ok_reg && (CMP_W'(rd_data_reg.arrival) <= time_ext);
    assign better   = best_none_reg ||
                      (rd_data_reg.remaining < best_rem_reg) ||
                      ((rd_data_reg.remaining == best_rem_reg) &&
                       (rd_data_reg.arrival < best_arr_reg));

    // Completion figures of the served job; waiting clamps at zero.
    assign rem_new   = rd_data_reg.remaining - 1'b1;
    assign finished  = (rem_new == '0);
    assign fin_w     = CMP_W'(time_inc);
    assign tat_w     = fin_w - CMP_W'(rd_data_reg.arrival);
    assign burst_ext = CMP_W'(rd_data_reg.burst);
    assign wait_w    = (tat_w >= burst_ext) ? tat_w - burst_ext : '0;

    // Status toward the controller.
    always_comb begin
        stat.kind_load  = (kind_reg == sjfs_pkg::KIND_LOAD);
        stat.kind_tick  = (kind_reg == sjfs_pkg::KIND_TICK);
        stat.burst_zero = (burst_reg == '0);
        stat.lock_use   = !preempt && lock_held_reg && valid_reg[locked_reg];
        stat.slot_free  = !valid_reg[cnt_reg];
        stat.cnt_last   = (cnt_reg == LAST_IDX);
        stat.best_none  = best_none_reg;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // Next-state logic driven by the controller commands.
    always_comb begin
        valid_next      = valid_reg;
        time_next       = time_reg;
        lock_held_next  = lock_held_reg;
        locked_next     = locked_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        arr_next        = arr_reg;
        burst_next      = burst_reg;
        cnt_next        = cnt_reg;
        pipe_vld_next   = cmd.scan_read;
        pipe_slot_next  = pipe_slot_reg;
        pipe_ok_next    = pipe_ok_reg;
        best_none_next  = best_none_reg;
        best_slot_next  = best_slot_reg;
        best_rem_next   = best_rem_reg;
        best_arr_next   = best_arr_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_done_next   = res_done_reg;
        res_fin_next    = res_fin_reg;
        res_tat_next    = res_tat_reg;
        res_wait_next   = res_wait_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_done_next     = m_done_reg;
        m_fin_next      = m_fin_reg;
        m_tat_next      = m_tat_reg;
        m_wait_next     = m_wait_reg;
        m_now_next      = m_now_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg;

        // Item capture.
        if (cmd.capture) begin
            kind_next  = s_kind;
            id_next    = s_job_id;
            arr_next   = s_arrival_time;
            burst_next = s_burst_length;
        end

        // Slot counter.
        if (cmd.cnt_clear) begin
            cnt_next = '0;
        end
        if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + 1'b1;
        end

        // Selection scan: read one slot a cycle, compare it in the next cycle.
        if (cmd.scan_start) begin
            best_none_next = 1'b1;
        end
        if (cmd.scan_read) begin
            rd_en          = 1'b1;
            rd_addr        = cnt_reg;
            pipe_slot_next = cnt_reg;
            pipe_ok_next   = valid_reg[cnt_reg];
        end
        if (pipe_vld_reg && eligible && better) begin
            best_none_next = 1'b0;
            best_slot_next = pipe_slot_reg;
            best_rem_next  = rd_data_reg.remaining;
            best_arr_next  = rd_data_reg.arrival;
        end

        // Choice of the slot to serve and its read.
        if (cmd.sel_lock) begin
            k_next = locked_reg;
        end
        if (cmd.sel_best) begin
            k_next = best_slot_reg;
        end
        if (cmd.read_sel) begin
            rd_en   = 1'b1;
            rd_addr = k_reg;
        end

        // Load into the free slot found by the counter.
        if (cmd.load) begin
            wr_en               = 1'b1;
            wr_addr             = cnt_reg;
            wr_data.id          = id_reg;
            wr_data.arrival     = arr_reg;
            wr_data.remaining   = burst_reg;
            wr_data.burst       = burst_reg;
            valid_next[cnt_reg] = 1'b1;
            res_status_next     = sjfs_pkg::STAT_LOADED;
            res_id_next         = '0;
            res_done_next       = 1'b0;
            res_fin_next        = '0;
            res_tat_next        = '0;
            res_wait_next       = '0;
        end

        // Rejected load.
        if (cmd.reject) begin
            res_status_next = sjfs_pkg::STAT_REJECTED;
            res_id_next     = '0;
            res_done_next   = 1'b0;
            res_fin_next    = '0;
            res_tat_next    = '0;
            res_wait_next   = '0;
        end

        // Clear of table, time and lock.
        if (cmd.clear) begin
            valid_next      = '0;
            time_next       = '0;
            lock_held_next  = 1'b0;
            locked_next     = '0;
            res_status_next = sjfs_pkg::STAT_CLEARED;
            res_id_next     = '0;
            res_done_next   = 1'b0;
            res_fin_next    = '0;
            res_tat_next    = '0;
            res_wait_next   = '0;
        end

        // Tick with no eligible job.
        if (cmd.idle_tick) begin
            time_next       = time_inc;
            lock_held_next  = 1'b0;
            res_status_next = sjfs_pkg::STAT_IDLE;
            res_id_next     = '0;
            res_done_next   = 1'b0;
            res_fin_next    = '0;
            res_tat_next    = '0;
            res_wait_next   = '0;
        end

        // Serve the chosen job for one unit and write back its remainder.
        if (cmd.exec) begin
            wr_en             = 1'b1;
            wr_addr           = k_reg;
            wr_data           = rd_data_reg;
            wr_data.remaining = rem_new;
            time_next         = time_inc;
            lock_held_next    = !preempt && !finished;
            if (!preempt) begin
                locked_next = k_reg;
            end
            if (finished) begin
                valid_next[k_reg] = 1'b0;
            end
            res_status_next = sjfs_pkg::STAT_RAN;
            res_id_next     = rd_data_reg.id;
            res_done_next   = finished;
            res_fin_next    = finished ? fin_w[FW-1:0] : '0;
            res_tat_next    = finished ? tat_w[FW-1:0] : '0;
            res_wait_next   = finished ? wait_w[FW-1:0] : '0;
        end

        // Output register: a taken beat frees it, a publish refills it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.publish) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_id_next     = res_id_reg;
            m_done_next   = res_done_reg;
            m_fin_next    = res_fin_reg;
            m_tat_next    = res_tat_reg;
            m_wait_next   = res_wait_reg;
            m_now_next    = time_ext[FW-1:0];
        end
    end

    // Slot memory: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem_reg[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            time_reg      <= '0;
            lock_held_reg <= 1'b0;
            locked_reg    <= '0;
            pipe_vld_reg  <= 1'b0;
            best_none_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            time_reg      <= time_next;
            lock_held_reg <= lock_held_next;
            locked_reg    <= locked_next;
            pipe_vld_reg  <= pipe_vld_next;
            best_none_reg <= best_none_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        arr_reg        <= arr_next;
        burst_reg      <= burst_next;
        cnt_reg        <= cnt_next;
        pipe_slot_reg  <= pipe_slot_next;
        pipe_ok_reg    <= pipe_ok_next;
        best_slot_reg  <= best_slot_next;
        best_rem_reg   <= best_rem_next;
        best_arr_reg   <= best_arr_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_done_reg   <= res_done_next;
        res_fin_reg    <= res_fin_next;
        res_tat_reg    <= res_tat_next;
        res_wait_reg   <= res_wait_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_done_reg     <= m_done_next;
        m_fin_reg      <= m_fin_next;
        m_tat_reg      <= m_tat_next;
        m_wait_reg     <= m_wait_next;
        m_now_reg      <= m_now_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_running_id  = m_id_reg;
    assign m_job_done    = m_done_reg;
    assign m_finish_time = m_fin_reg;
    assign m_turnaround  = m_tat_reg;
    assign m_waiting     = m_wait_reg;
    assign m_now_time    = m_now_reg;

endmodule
